// ===== rtl/mmm_pkg.sv =====
package mmm_pkg;

  localparam int MaxMotors = 8;
  localparam int OneQ14 = 16384;
  localparam int MixW = 48;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegMode  = 3'd0;
  localparam logic [2:0] RegCount = 3'd1;
  localparam logic [2:0] RegRoll  = 3'd2;
  localparam logic [2:0] RegPitch = 3'd3;
  localparam logic [2:0] RegYaw   = 3'd4;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    logic               wing_mode;
    logic [3:0]         count;
    logic [14:0]        thr;
    logic signed [31:0] roll_term;
    logic signed [31:0] pitch_term;
    logic signed [31:0] yaw_term;
  } cmd_t;

  typedef logic signed [15:0] coef_row_t [0:7];
  typedef coef_row_t coef_tab_t [0:7];

  localparam coef_tab_t PitchTab = '{
    '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, -16'sd8192, -16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd11585, 16'sd11585, -16'sd11585, -16'sd11585, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, 16'sd5063, -16'sd13255, -16'sd13255, 16'sd5063, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, 16'sd8192, -16'sd8192, -16'sd16384, -16'sd8192, 16'sd8192, 16'sd0,
      16'sd0},
    '{16'sd16384, 16'sd10215, -16'sd3646, -16'sd14761, -16'sd14761, -16'sd3646,
      16'sd10215, 16'sd0},
    '{16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384, -16'sd11585, 16'sd0,
      16'sd11585}
  };

  localparam coef_tab_t RollTab = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, -16'sd14189, 16'sd14189, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd11585, 16'sd11585, 16'sd11585, -16'sd11585, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, -16'sd15582, -16'sd9630, 16'sd9630, 16'sd15582, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, -16'sd14189, -16'sd14189, 16'sd0, 16'sd14189, 16'sd14189, 16'sd0, 16'sd0},
    '{16'sd0, -16'sd12810, -16'sd15973, -16'sd7109, 16'sd7109, 16'sd15973, 16'sd12810,
      16'sd0},
    '{16'sd0, -16'sd11585, -16'sd16384, -16'sd11585, 16'sd0, 16'sd11585, 16'sd16384,
      16'sd11585}
  };

endpackage

// ===== rtl/mmm_front.sv =====
module mmm_front #(
  parameter int NUM_ROTORS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic signed [15:0] throttle,
  input  logic signed [15:0] roll,
  input  logic signed [15:0] pitch,
  input  logic signed [15:0] yaw,
  output mmm_pkg::cmd_t      cmd
);

  logic        airframe_mode;
  logic [3:0]  attached_motors;
  logic [14:0] gain_roll;
  logic [14:0] gain_pitch;
  logic [14:0] gain_yaw;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      airframe_mode   <= 1'b0;
      attached_motors <= 4'd4;
      gain_roll       <= 15'd7373;
      gain_pitch      <= 15'd7373;
      gain_yaw        <= 15'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mmm_pkg::RegMode:  airframe_mode   <= cfg_data[0];
        mmm_pkg::RegCount: attached_motors <= cfg_data[3:0];
        mmm_pkg::RegRoll:  gain_roll       <= cfg_data[14:0];
        mmm_pkg::RegPitch: gain_pitch      <= cfg_data[14:0];
        mmm_pkg::RegYaw:   gain_yaw        <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] rol_c, pit_c, yaw_c;
  logic [14:0]        thr_c;

  // Clamp the command to its legal ranges.
  always_comb begin
    if (throttle < 16'sd0) thr_c = 15'd0;
    else if (throttle > 16'sd16384) thr_c = 15'd16384;
    else thr_c = throttle[14:0];
    if (roll < -16'sd16384) rol_c = -16'sd16384;
    else if (roll > 16'sd16384) rol_c = 16'sd16384;
    else rol_c = roll;
    if (pitch < -16'sd16384) pit_c = -16'sd16384;
    else if (pitch > 16'sd16384) pit_c = 16'sd16384;
    else pit_c = pitch;
    if (yaw < -16'sd16384) yaw_c = -16'sd16384;
    else if (yaw > 16'sd16384) yaw_c = 16'sd16384;
    else yaw_c = yaw;
  end

  // Gain-weighted axis terms and the number of motors to drive.
  always_comb begin
    cmd.wing_mode  = airframe_mode;
    cmd.thr        = thr_c;
    cmd.roll_term  = $signed({1'b0, gain_roll}) * rol_c;
    cmd.pitch_term = $signed({1'b0, gain_pitch}) * pit_c;
    cmd.yaw_term   = $signed({1'b0, gain_yaw}) * yaw_c;
    if (airframe_mode) begin
      cmd.count = (attached_motors > 4'(mmm_pkg::MaxMotors)) ?
                  4'(mmm_pkg::MaxMotors) : attached_motors;
    end else begin
      cmd.count = (attached_motors > 4'(NUM_ROTORS)) ? 4'(NUM_ROTORS) : attached_motors;
    end
  end

endmodule

// ===== rtl/mmm_queue.sv =====
module mmm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mmm_pkg::cmd_t push_word,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output mmm_pkg::cmd_t head
);

  mmm_pkg::cmd_t slots [0:1];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full     = (fill == 2'd2);
  assign nonempty = (fill != 2'd0);
  assign head     = slots[rd_ptr];

  // Two-word queue between the front and the back.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

endmodule

// ===== rtl/mmm_back.sv =====
module mmm_back #(
  parameter int NUM_ROTORS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_nonempty,
  input  mmm_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    motor_index,
  output logic [14:0]   motor_throttle,
  output logic          last_motor
);

  localparam int Row = NUM_ROTORS - 1;
  localparam int W = mmm_pkg::MixW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MIX, ST_PREP, ST_CALC, ST_DIV, ST_FIN, ST_EMIT
  } state_t;

  state_t               state;
  mmm_pkg::cmd_t        cmd;
  logic [2:0]           idx;
  logic                 phase;
  logic signed [W-1:0]  acc;
  logic signed [W-1:0]  mix [0:7];
  logic signed [W-1:0]  mn, mx;
  logic                 sat, big;
  logic [W-1:0]         span;
  logic [63:0]          rem;
  logic [63:0]          den;
  logic [3:0]           k;
  logic [14:0]          quo;
  logic                 neg;
  logic [14:0]          res;

  // Coefficients of the current motor and the shared multiplier.
  logic signed [15:0]   coef;
  logic signed [31:0]   mul_a;
  logic signed [W-1:0]  prod;
  logic signed [W-1:0]  thr_w, yaw_w, sum0, sum1;
  logic                 slot_free;
  logic                 is_last;
  logic                 emit_now;

  always_comb begin
    coef  = phase ? mmm_pkg::PitchTab[Row][idx] : mmm_pkg::RollTab[Row][idx];
    mul_a = phase ? cmd.pitch_term : cmd.roll_term;
    prod  = W'(mul_a) * W'(coef);
    thr_w = $signed({5'd0, cmd.thr, 28'd0});
    yaw_w = idx[0] ? -$signed({{2{cmd.yaw_term[31]}}, cmd.yaw_term, 14'd0})
                   : $signed({{2{cmd.yaw_term[31]}}, cmd.yaw_term, 14'd0});
    sum0  = thr_w + yaw_w + prod;
    sum1  = acc + prod;
  end

  assign slot_free = !out_valid || out_ready;
  assign emit_now  = (state == ST_EMIT) && slot_free;
  assign is_last   = ({1'b0, idx} + 4'd1) == cmd.count;
  assign q_pop     = (state == ST_IDLE) && q_nonempty;

  // Per-motor desaturation terms.
  logic signed [W+1:0]  d2;
  logic [W+1:0]         d2_mag;
  logic [W+1:0]         rnd29;
  logic signed [16:0]   q_small;
  logic signed [W-1:0]  m_cur;
  logic [W-1:0]         rnd28;
  logic [63:0]          den_k;
  logic signed [17:0]   q_div;
  logic signed [17:0]   sum_small;
  logic signed [17:0]   sum_div;

  always_comb begin
    m_cur   = mix[idx];
    d2      = (W+2)'(m_cur) * 2 - (W+2)'(mn) - (W+2)'(mx);
    d2_mag  = d2[W+1] ? (W+2)'(-d2) : (W+2)'(d2);
    rnd29   = (d2_mag + (W+2)'(64'd1 << 28)) >> 29;
    q_small = d2[W+1] ? -$signed({1'b0, rnd29[15:0]}) : $signed({1'b0, rnd29[15:0]});
    rnd28   = (W'(m_cur) + W'(64'd1 << 28 >> 1)) >> 28;
    den_k   = den << k;
    q_div   = neg ? -$signed({3'd0, quo}) : $signed({3'd0, quo});
    sum_small = 18'(q_small) + $signed({3'd0, cmd.thr});
    sum_div   = q_div + $signed({3'd0, cmd.thr});
  end

  function automatic logic [14:0] clamp_q14(input logic signed [17:0] v);
    if (v < 18'sd0) return 15'd0;
    else if (v > 18'sd16384) return 15'd16384;
    else return v[14:0];
  endfunction

  // Sequencer, mix store and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit_now || (out_valid && !out_ready);
      unique case (state)
        ST_IDLE: begin
          if (q_nonempty) begin
            cmd   <= q_head;
            idx   <= 3'd0;
            phase <= 1'b0;
            if (q_head.count == 4'd0) state <= ST_IDLE;
            else if (q_head.wing_mode) state <= ST_EMIT;
            else state <= ST_MIX;
          end
        end
        ST_MIX: begin
          phase <= ~phase;
          if (!phase) begin
            acc <= sum0;
          end else begin
            mix[idx] <= sum1;
            if (idx == 3'd0 || sum1 < mn) mn <= sum1;
            if (idx == 3'd0 || sum1 > mx) mx <= sum1;
            if (is_last) begin
              idx   <= 3'd0;
              state <= ST_PREP;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        ST_PREP: begin
          span  <= W'(mx - mn);
          sat   <= (mn < 0) || (mx > $signed(W'(64'd1 << 42)));
          big   <= (mx - mn) > $signed(W'(64'd1 << 42));
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (!sat) begin
            res   <= clamp_q14($signed({1'b0, rnd28[16:0]}));
            state <= ST_EMIT;
          end else if (!big) begin
            res   <= clamp_q14(sum_small);
            state <= ST_EMIT;
          end else begin
            rem   <= (64'(d2_mag) << 14) + 64'(span);
            den   <= 64'(span) << 1;
            neg   <= d2[W+1];
            k     <= 4'd14;
            quo   <= 15'd0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem >= den_k) begin
            rem    <= rem - den_k;
            quo[k] <= 1'b1;
          end
          if (k == 4'd0) state <= ST_FIN;
          else k <= k - 4'd1;
        end
        ST_FIN: begin
          res   <= clamp_q14(sum_div);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            motor_index <= idx;
            last_motor  <= is_last;
            if (cmd.wing_mode) motor_throttle <= (idx == 3'd0) ? cmd.thr : 15'd0;
            else motor_throttle <= res;
            if (is_last) state <= ST_IDLE;
            else begin
              idx   <= idx + 3'd1;
              state <= cmd.wing_mode ? ST_EMIT : ST_CALC;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/multirotor_motor_mixer_unit.sv =====
// Motor mixer: one command word (throttle, roll, pitch, yaw, Q2.14) gives one result
// word per driven motor, in motor order, with last_motor on the final one. A command
// is taken into a two-word queue; the back end loads it, then mixes each motor in two
// phases (roll, then pitch) on one shared multiplier, checks the span, and per motor
// scales and emits the result, running the 15-step divider when the span exceeds 1.0.
// Output stalls hold the emit. Fixed-wing mode skips the mix and emits each motor
// after the load.
module multirotor_motor_mixer_unit #(
  parameter int NUM_ROTORS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] throttle,
  input  logic signed [15:0] roll,
  input  logic signed [15:0] pitch,
  input  logic signed [15:0] yaw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         motor_index,
  output logic [14:0]        motor_throttle,
  output logic               last_motor
);

  mmm_pkg::cmd_t cmd_in, cmd_head;
  logic          q_full, q_nonempty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  mmm_front #(.NUM_ROTORS(NUM_ROTORS)) u_front (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .throttle(throttle), .roll(roll), .pitch(pitch),
    .yaw(yaw), .cmd(cmd_in)
  );

  mmm_queue u_queue (
    .clk(clk), .rst(rst), .push(in_valid && !q_full), .push_word(cmd_in),
    .full(q_full), .pop(q_pop), .nonempty(q_nonempty), .head(cmd_head)
  );

  mmm_back #(.NUM_ROTORS(NUM_ROTORS)) u_back (
    .clk(clk), .rst(rst), .q_nonempty(q_nonempty), .q_head(cmd_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .motor_index(motor_index),
    .motor_throttle(motor_throttle), .last_motor(last_motor)
  );

  // A result never exceeds full throttle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> motor_throttle <= 15'd16384)
    else $error("motor throttle above 1.0");

  // After the final word of a command the next word starts at motor zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_motor |=> !out_valid || motor_index == 3'd0)
    else $error("new command does not start at motor zero");

  // Within a command the motor number steps by one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_motor |=>
      !out_valid || motor_index == 3'($past(motor_index) + 3'd1))
    else $error("motor number skipped");

endmodule

// ===== sim/multirotor_motor_mixer_checker.sv =====
`timescale 1ns / 1ps

module multirotor_motor_mixer_checker #(
  parameter int NUM_ROTORS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] throttle,
  input  logic signed [15:0] roll,
  input  logic signed [15:0] pitch,
  input  logic signed [15:0] yaw,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         motor_index,
  input  logic [14:0]        motor_throttle,
  input  logic               last_motor,
  output int                 pending,
  output int                 failures
);

  typedef struct packed {
    logic [2:0]  idx;
    logic [14:0] thr;
    logic        last;
  } motor_word_t;

  motor_word_t motor_words_due[$];

  // Local copy of the configuration registers.
  logic        wing_mode;
  logic [3:0]  motors_attached;
  logic [14:0] gain_roll;
  logic [14:0] gain_pitch;
  logic [14:0] gain_yaw;

  initial begin
    failures = 0;
    pending = 0;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
    failures++;
  endtask

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Division rounded half away from zero.
  function automatic longint div_round(input longint num, input longint den);
    longint mag;
    mag = num < 0 ? -num : num;
    mag = (mag + den / 2) / den;
    return num < 0 ? -mag : mag;
  endfunction

  // Works out the per-motor throttle words for one command.
  task automatic mix_command(input logic signed [15:0] t_in, input logic signed [15:0] r_in,
                             input logic signed [15:0] p_in, input logic signed [15:0] y_in);
    longint thr, rol, pit, yw, mn, mx, span, d2, q;
    longint mix [8];
    longint res [8];
    longint one42;
    int n, row, i;
    motor_word_t w;
    thr = clip(longint'(t_in), 0, mmm_pkg::OneQ14);
    rol = clip(longint'(r_in), -mmm_pkg::OneQ14, mmm_pkg::OneQ14);
    pit = clip(longint'(p_in), -mmm_pkg::OneQ14, mmm_pkg::OneQ14);
    yw  = clip(longint'(y_in), -mmm_pkg::OneQ14, mmm_pkg::OneQ14);
    one42 = longint'(1) << 42;
    n = motors_attached > 8 ? 8 : int'(motors_attached);
    row = (NUM_ROTORS - 1) & 7;
    if (wing_mode) begin
      for (i = 0; i < n; i++) res[i] = (i == 0) ? thr : 0;
    end else begin
      if (n > NUM_ROTORS) n = NUM_ROTORS;
      for (i = 0; i < n; i++) begin
        mix[i] = (thr <<< 28)
               + longint'(gain_roll) * longint'(mmm_pkg::RollTab[row][i]) * rol
               + longint'(gain_pitch) * longint'(mmm_pkg::PitchTab[row][i]) * pit
               + longint'(gain_yaw) * ((i & 1) ? -1 : 1) * mmm_pkg::OneQ14 * yw;
      end
      if (n > 0) begin
        mn = mix[0];
        mx = mix[0];
        for (i = 1; i < n; i++) begin
          if (mix[i] < mn) mn = mix[i];
          if (mix[i] > mx) mx = mix[i];
        end
        // Desaturation: recentre on throttle and shrink when the span exceeds 1.0.
        if (mn < 0 || mx > one42) begin
          span = mx - mn;
          for (i = 0; i < n; i++) begin
            d2 = 2 * mix[i] - mn - mx;
            if (span <= one42) q = div_round(d2, longint'(1) << 29);
            else q = div_round(d2 * mmm_pkg::OneQ14, 2 * span);
            res[i] = clip(q + thr, 0, mmm_pkg::OneQ14);
          end
        end else begin
          for (i = 0; i < n; i++)
            res[i] = clip(div_round(mix[i], longint'(1) << 28), 0, mmm_pkg::OneQ14);
        end
      end
    end
    for (i = 0; i < n; i++) begin
      w.idx = i[2:0];
      w.thr = res[i][14:0];
      w.last = (i + 1 == n);
      motor_words_due.insert(motor_words_due.size(), w);
    end
  endtask

  always @(posedge clk) begin
    motor_word_t w;
    if (rst) begin
      wing_mode <= 1'b0;
      motors_attached <= 4'd4;
      gain_roll <= 15'd7373;
      gain_pitch <= 15'd7373;
      gain_yaw <= 15'd4096;
    end else begin
      // Compare each delivered result word with the oldest one due.
      if (out_valid && out_ready) begin
        if (motor_words_due.size() == 0) begin
          report("unexpected result word, motor_index", motor_index, -1);
        end else begin
          w = motor_words_due.pop_front();
          if (motor_index !== w.idx) report("motor_index", motor_index, w.idx);
          if (motor_throttle !== w.thr) report("motor_throttle", motor_throttle, w.thr);
          if (last_motor !== w.last) report("last_motor", last_motor, w.last);
        end
      end
      if (in_valid && in_ready) mix_command(throttle, roll, pitch, yaw);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mmm_pkg::RegMode:  wing_mode <= cfg_data[0];
          mmm_pkg::RegCount: motors_attached <= cfg_data[3:0];
          mmm_pkg::RegRoll:  gain_roll <= cfg_data[14:0];
          mmm_pkg::RegPitch: gain_pitch <= cfg_data[14:0];
          mmm_pkg::RegYaw:   gain_yaw <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
    pending = motor_words_due.size();
  end

  final if (motor_words_due.size() != 0) $display("ERROR: %0d result words never arrived",
                                                   motor_words_due.size());
endmodule

// ===== sim/multirotor_motor_mixer_unit_tb.sv =====
`timescale 1ns / 1ps

module multirotor_motor_mixer_unit_tb;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] throttle;
  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic signed [15:0] yaw;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         motor_index;
  logic [14:0]        motor_throttle;
  logic               last_motor;
  int                 pending;
  int                 failures;
  int                 send_idle_pct;
  int                 stall_pct;

  multirotor_motor_mixer_unit dut (.*);

  multirotor_motor_mixer_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // Writes one configuration register; called at a falling edge.
  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits for every due result word, lets the block settle, then reprograms it.
  task automatic set_airframe(input int mode, input int n, input int gr, input int gp,
                              input int gy);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(negedge clk);
    write_reg(mmm_pkg::RegMode, mode);
    write_reg(mmm_pkg::RegCount, n);
    write_reg(mmm_pkg::RegRoll, gr);
    write_reg(mmm_pkg::RegPitch, gp);
    write_reg(mmm_pkg::RegYaw, gy);
  endtask

  // Sends one command word; entered and left at a falling edge.
  task automatic send_cmd(input int t, input int r, input int p, input int y);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    throttle <= t[15:0];
    roll <= r[15:0];
    pitch <= p[15:0];
    yaw <= y[15:0];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Mostly in-range values, with extremes and the full 16-bit range mixed in.
  function automatic int pick_field(input bit is_thr);
    case ($urandom_range(9))
      0: return int'($urandom_range(65535)) - 32768;
      1: return ($urandom_range(1)) ? 32767 : -32768;
      2: return ($urandom_range(1)) ? mmm_pkg::OneQ14 : (is_thr ? 0 : -mmm_pkg::OneQ14);
      default: return is_thr ? int'($urandom_range(mmm_pkg::OneQ14))
                             : int'($urandom_range(2 * mmm_pkg::OneQ14)) - mmm_pkg::OneQ14;
    endcase
  endfunction

  task automatic random_cmds(input int n);
    repeat (n) send_cmd(pick_field(1), pick_field(0), pick_field(0), pick_field(0));
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 47; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 47; end
      default: begin send_idle_pct = 20; stall_pct = 20; end
    endcase
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    throttle = '0;
    roll = '0;
    pitch = '0;
    yaw = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed commands with the reset configuration.
    send_cmd(0, 0, 0, 0);
    send_cmd(16384, 0, 0, 0);
    send_cmd(32767, 32767, 32767, 32767);
    send_cmd(-32768, -32768, -32768, -32768);
    send_cmd(-1, -1, -1, -1);
    send_cmd(8192, 16384, 0, 0);
    send_cmd(8192, -16384, 0, 0);
    send_cmd(8192, 0, 16384, 0);
    send_cmd(8192, 0, -16384, 0);
    send_cmd(8192, 0, 0, 16384);
    send_cmd(8192, 0, 0, -16384);
    send_cmd(16384, 16384, 16384, 16384);
    send_cmd(0, -16384, 16384, -16384);
    send_cmd(16385, 16385, -16385, 16385);
    send_cmd(12000, 3000, -2000, 1000);
    send_cmd(1000, 500, 500, 500);
    send_cmd(21845, -21846, 10922, -5461);
    random_cmds(40);

    // Phases through the extremes of every register.
    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: set_airframe(0, 4, 32767, 32767, 32767);
        2: set_airframe(1, 8, 7373, 7373, 4096);
        3: set_airframe(0, 0, 16384, 16384, 16384);
        4: set_airframe(0, 15, 0, 0, 0);
        5: set_airframe(1, 15, 32767, 0, 32767);
        6: set_airframe(0, 2, 16384, 16384, 16384);
        7: set_airframe(1, 0, 100, 100, 100);
        default: set_airframe(0, 3, $urandom_range(32767), $urandom_range(32767),
                              $urandom_range(32767));
      endcase
      set_idling(ph);
      random_cmds((ph == 3 || ph == 7) ? 8 : 50);
    end
    set_airframe(0, 4, $urandom_range(16384), $urandom_range(16384), $urandom_range(16384));
    set_idling(3);
    random_cmds(30);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(negedge clk);
    if (failures == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d result words still due", pending);
    $display("== FAIL ==");
    $finish;
  end
endmodule
